>>> sv/mmvc_pkg.sv
`default_nettype none

package mmvc_pkg;

    // Parser position within a MIDI message.
    typedef enum logic [1:0] {
        PHASE_STATUS,
        PHASE_DATA1,
        PHASE_DATA2
    } mmvc_phase_t;

    // Sequencer states of the pitch stack engine.
    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_POP,
        ENG_DECIDE,
        ENG_DIVIDE,
        ENG_SPLIT,
        ENG_EMIT
    } mmvc_eng_state_t;

    // Note command kinds passed from the parser to the engine.
    typedef enum logic {
        OP_NOTE_ON,
        OP_NOTE_OFF
    } mmvc_op_t;

    typedef struct packed {
        mmvc_op_t   op;
        logic [7:0] pitch;
    } mmvc_cmd_t;

    // Voice request from the engine: gate plus the split pitch.
    typedef struct packed {
        logic       gate_on;
        logic [3:0] octave;
        logic [3:0] semitone;
    } mmvc_req_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_WAVEFORM_SELECT = 3'd0;
    localparam logic [2:0] CFG_CARRIER_OCTAVE  = 3'd1;
    localparam logic [2:0] CFG_MESSAGE_GAIN    = 3'd2;
    localparam logic [2:0] CFG_MESSAGE_WAVE    = 3'd3;
    localparam logic [2:0] CFG_MODULATED_GAIN  = 3'd4;
    localparam logic [2:0] CFG_MODULATED_WAVE  = 3'd5;
    localparam logic [2:0] CFG_ATTACK_RATE     = 3'd6;
    localparam logic [2:0] CFG_RELEASE_RATE    = 3'd7;

    // MIDI status codes.
    localparam logic [7:0] SYSTEM_MIN      = 8'hF0;
    localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
    localparam logic [3:0] KIND_POLY_PRESS = 4'hA;
    localparam logic [3:0] KIND_CONTROL    = 4'hB;
    localparam logic [3:0] KIND_PITCH_BEND = 4'hE;
    localparam logic [3:0] CHANNEL_0       = 4'h0;

    // Pitch limits.
    localparam logic [7:0] PITCH_LOW  = 8'd12;
    localparam logic [7:0] PITCH_HIGH = 8'd107;

    // Division by 12 as multiply by 43 and shift right by 9 (exact up to 119).
    localparam logic [5:0] RECIP_12    = 6'd43;
    localparam int         RECIP_SHIFT = 9;

    // Control byte codes.
    localparam logic [7:0] CTRL_GATE   = 8'h80;
    localparam logic [2:0] WAVE_PM     = 3'd4;
    localparam logic [7:0] CTRL_PM_OFF = 8'h04;

    function automatic logic has_two_data(input logic [7:0] status);
        logic [3:0] kind;
        kind = status[7:4];
        return (kind == KIND_NOTE_OFF) || (kind == KIND_NOTE_ON) ||
               (kind == KIND_POLY_PRESS) || (kind == KIND_CONTROL) ||
               (kind == KIND_PITCH_BEND);
    endfunction

    function automatic logic in_play_range(input logic [7:0] pitch);
        return (pitch >= PITCH_LOW) && (pitch <= PITCH_HIGH);
    endfunction

    // Phase increment of each semitone within an octave.
    function automatic logic [11:0] note_delta(input logic [3:0] semitone);
        logic [11:0] delta;
        case (semitone)
            4'd0:    delta = 12'd702;
            4'd1:    delta = 12'd744;
            4'd2:    delta = 12'd788;
            4'd3:    delta = 12'd835;
            4'd4:    delta = 12'd885;
            4'd5:    delta = 12'd937;
            4'd6:    delta = 12'd993;
            4'd7:    delta = 12'd1052;
            4'd8:    delta = 12'd1115;
            4'd9:    delta = 12'd1181;
            4'd10:   delta = 12'd1251;
            4'd11:   delta = 12'd1326;
            default: delta = 12'd0;
        endcase
        return delta;
    endfunction

endpackage

`default_nettype wire

>>> sv/mmvc_engine.sv
`default_nettype none

module mmvc_engine #(
    parameter int STACK_DEPTH = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    input  mmvc_pkg::mmvc_cmd_t cmd,
    output logic                cmd_ready,
    output logic                req_valid,
    output mmvc_pkg::mmvc_req_t req,
    input  wire                 req_ready
);

    localparam int AW = $clog2(STACK_DEPTH);

    mmvc_pkg::mmvc_eng_state_t state_reg, state_next;

    logic [AW-1:0] top_reg, top_next;
    logic [7:0]    last_pitch_reg, last_pitch_next;
    logic [7:0]    pitch_reg, pitch_next;
    logic [AW:0]   scan_idx_reg, scan_idx_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next;
    logic          found_reg, found_next;
    logic          gate_reg, gate_next;
    logic [3:0]    quot_reg, quot_next;
    logic [3:0]    semi_reg, semi_next;

    // Pitch stack memory; entry 0 is never written and reads as zero.
    logic [7:0]    mem [STACK_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    rd_data_reg;
    logic          rd_zero_reg;

    logic          on_room;
    logic          on_new;
    logic [7:0]    top_val;
    logic          top_pos;
    logic          top_new;
    logic          scan_more;
    logic [12:0]   recip_prod;
    logic [6:0]    semi_full;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
        rd_zero_reg <= (mem_raddr == '0);
    end

    // Shared decision terms.
    assign on_room    = ({1'b0, top_reg} < (AW + 1)'(STACK_DEPTH - 1));
    assign on_new     = (cmd.pitch != last_pitch_reg);
    assign top_val    = rd_zero_reg ? 8'd0 : rd_data_reg;
    assign top_pos    = (top_val != 8'd0) && !top_val[7];
    assign top_new    = (top_val != last_pitch_reg);
    assign scan_more  = (scan_idx_reg <= {1'b0, top_reg});
    assign recip_prod = 13'(pitch_reg[6:0]) * 13'(mmvc_pkg::RECIP_12);
    assign semi_full  = pitch_reg[6:0] - ({quot_reg, 3'b000} + {1'b0, quot_reg, 2'b00});

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mmvc_pkg::ENG_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == mmvc_pkg::OP_NOTE_OFF)
                    begin
                        state_next = mmvc_pkg::ENG_SCAN;
                    end
                    else if (on_room && on_new)
                    begin
                        state_next = mmvc_pkg::in_play_range(cmd.pitch) ?
                                     mmvc_pkg::ENG_DIVIDE : mmvc_pkg::ENG_EMIT;
                    end
                end
            end
            mmvc_pkg::ENG_SCAN:
            begin
                if (!scan_more && !chk_valid_reg)
                begin
                    state_next = mmvc_pkg::ENG_POP;
                end
            end
            mmvc_pkg::ENG_POP:
            begin
                state_next = mmvc_pkg::ENG_DECIDE;
            end
            mmvc_pkg::ENG_DECIDE:
            begin
                if (!top_pos)
                begin
                    state_next = mmvc_pkg::ENG_EMIT;
                end
                else if (top_new)
                begin
                    state_next = mmvc_pkg::in_play_range(top_val) ?
                                 mmvc_pkg::ENG_DIVIDE : mmvc_pkg::ENG_EMIT;
                end
                else
                begin
                    state_next = mmvc_pkg::ENG_IDLE;
                end
            end
            mmvc_pkg::ENG_DIVIDE:
            begin
                state_next = mmvc_pkg::ENG_SPLIT;
            end
            mmvc_pkg::ENG_SPLIT:
            begin
                state_next = mmvc_pkg::ENG_EMIT;
            end
            mmvc_pkg::ENG_EMIT:
            begin
                if (req_ready)
                begin
                    state_next = mmvc_pkg::ENG_IDLE;
                end
            end
            default:
            begin
                state_next = mmvc_pkg::ENG_IDLE;
            end
        endcase
    end

    // Datapath, memory access and handshake outputs.
    always_comb
    begin
        cmd_ready       = 1'b0;
        req_valid       = 1'b0;
        req             = '{gate_on: gate_reg, octave: quot_reg, semitone: semi_reg};
        mem_we          = 1'b0;
        mem_waddr       = chk_idx_reg - 1'b1;
        mem_wdata       = rd_data_reg;
        mem_raddr       = scan_idx_reg[AW-1:0];
        top_next        = top_reg;
        last_pitch_next = last_pitch_reg;
        pitch_next      = pitch_reg;
        scan_idx_next   = scan_idx_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        gate_next       = gate_reg;
        quot_next       = quot_reg;
        semi_next       = semi_reg;
        unique case (state_reg)
            mmvc_pkg::ENG_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (cmd.op == mmvc_pkg::OP_NOTE_OFF)
                    begin
                        pitch_next     = cmd.pitch;
                        scan_idx_next  = (AW + 1)'(1);
                        chk_valid_next = 1'b0;
                        found_next     = 1'b0;
                    end
                    else if (on_room)
                    begin
                        // Push onto the stack.
                        top_next  = top_reg + 1'b1;
                        mem_we    = 1'b1;
                        mem_waddr = top_reg + 1'b1;
                        mem_wdata = cmd.pitch;
                        if (on_new)
                        begin
                            last_pitch_next = cmd.pitch;
                            pitch_next      = cmd.pitch;
                            gate_next       = mmvc_pkg::in_play_range(cmd.pitch);
                        end
                    end
                end
            end
            mmvc_pkg::ENG_SCAN:
            begin
                // Read entries 1..top in turn; after a match, each later entry
                // moves down by one.
                if (scan_more)
                begin
                    scan_idx_next  = scan_idx_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg[AW-1:0];
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
                if (chk_valid_reg)
                begin
                    if (found_reg)
                    begin
                        mem_we = 1'b1;
                    end
                    else if ((chk_idx_reg < top_reg) && (rd_data_reg == pitch_reg))
                    begin
                        found_next = 1'b1;
                    end
                end
            end
            mmvc_pkg::ENG_POP:
            begin
                if (top_reg != '0)
                begin
                    top_next  = top_reg - 1'b1;
                    mem_raddr = top_reg - 1'b1;
                end
                else
                begin
                    mem_raddr = '0;
                end
            end
            mmvc_pkg::ENG_DECIDE:
            begin
                last_pitch_next = top_val;
                pitch_next      = top_val;
                gate_next       = top_pos && mmvc_pkg::in_play_range(top_val);
            end
            mmvc_pkg::ENG_DIVIDE:
            begin
                quot_next = recip_prod[mmvc_pkg::RECIP_SHIFT +: 4];
            end
            mmvc_pkg::ENG_SPLIT:
            begin
                semi_next = semi_full[3:0];
                quot_next = quot_reg + 4'd1;
            end
            mmvc_pkg::ENG_EMIT:
            begin
                req_valid = 1'b1;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mmvc_pkg::ENG_IDLE;
            top_reg        <= '0;
            last_pitch_reg <= 8'd0;
            scan_idx_reg   <= '0;
            chk_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            top_reg        <= top_next;
            last_pitch_reg <= last_pitch_next;
            scan_idx_reg   <= scan_idx_next;
            chk_valid_reg  <= chk_valid_next;
            found_reg      <= found_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pitch_reg   <= pitch_next;
        chk_idx_reg <= chk_idx_next;
        gate_reg    <= gate_next;
        quot_reg    <= quot_next;
        semi_reg    <= semi_next;
    end

    // The reserved bottom entry must never be overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (mem_waddr != '0))
        else $error("pitch stack write to bottom entry");

    // The scan never examines an entry above the stack top.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mmvc_pkg::ENG_SCAN && chk_valid_reg) |-> (chk_idx_reg <= top_reg))
        else $error("stack scan beyond top");

    // A note-on with room grows the stack by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mmvc_pkg::ENG_IDLE && cmd_valid && cmd.op == mmvc_pkg::OP_NOTE_ON
         && on_room) |=> (top_reg == $past(top_reg) + 1'b1))
        else $error("push did not advance stack top");

    // A pop of a non-empty stack shrinks it by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mmvc_pkg::ENG_POP && top_reg != '0)
        |=> (top_reg == $past(top_reg) - 1'b1))
        else $error("pop did not lower stack top");

endmodule

`default_nettype wire

>>> sv/midi_mono_voice_controller.sv
// Reset (rst_n, async, low). A note-on in the playable range passes the engine states
// DIVIDE, SPLIT and EMIT; a note-on that gives gate off goes straight to EMIT. EMIT
// holds until the output register takes the voice command. A note-off walks the N held
// pitches in the stack memory one entry a cycle, then passes POP and DECIDE. Other
// bytes finish in the cycle taken. Throughput: one byte per cycle outside note commands;
// a note command blocks new bytes until its voice command, if any, leaves the engine.
`default_nettype none

module midi_mono_voice_controller #(
    parameter int STACK_DEPTH = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    // Configuration write port.
    input  wire         cfg_wr_en,
    input  wire  [2:0]  cfg_index,
    input  wire  [5:0]  cfg_wdata,
    // MIDI byte stream.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] midi_byte
    // Voice command stream.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [7:0] control_byte, [23:8] phase_word,
                                        // [29:24] octave_sum, [37:30] message_byte,
                                        // [45:38] modulated_byte, [53:46] envelope_byte
    output logic [0:0]  m_axis_tuser    // [0] gate_on
);

    // Configuration registers.
    logic [2:0] waveform_select_reg;
    logic [3:0] carrier_octave_reg;
    logic [5:0] message_gain_reg;
    logic [1:0] message_wave_reg;
    logic [5:0] modulated_gain_reg;
    logic [1:0] modulated_wave_reg;
    logic [3:0] attack_rate_reg;
    logic [3:0] release_rate_reg;

    // Parser state.
    mmvc_pkg::mmvc_phase_t phase_reg, phase_next;
    logic [7:0] running_status_reg, running_status_next;
    logic [7:0] current_status_reg, current_status_next;
    logic [7:0] first_data_reg, first_data_next;

    logic                in_fire;
    logic [7:0]          in_byte;
    logic                cmd_valid;
    mmvc_pkg::mmvc_cmd_t cmd;
    logic                cmd_ready;
    logic                req_valid;
    mmvc_pkg::mmvc_req_t req;
    logic                req_ready;

    // Output register.
    logic        out_valid_reg;
    logic [55:0] out_tdata_reg;
    logic        out_tuser_reg;
    logic [55:0] out_tdata_next;
    logic [7:0]  control_byte;
    logic [5:0]  octave_sum;

    assign in_byte       = s_axis_tdata;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = cmd_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_select_reg <= 3'd4;
            carrier_octave_reg  <= 4'd0;
            message_gain_reg    <= 6'd63;
            message_wave_reg    <= 2'd0;
            modulated_gain_reg  <= 6'd63;
            modulated_wave_reg  <= 2'd0;
            attack_rate_reg     <= 4'd15;
            release_rate_reg    <= 4'd15;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                mmvc_pkg::CFG_WAVEFORM_SELECT: waveform_select_reg <= cfg_wdata[2:0];
                mmvc_pkg::CFG_CARRIER_OCTAVE:  carrier_octave_reg  <= cfg_wdata[3:0];
                mmvc_pkg::CFG_MESSAGE_GAIN:    message_gain_reg    <= cfg_wdata[5:0];
                mmvc_pkg::CFG_MESSAGE_WAVE:    message_wave_reg    <= cfg_wdata[1:0];
                mmvc_pkg::CFG_MODULATED_GAIN:  modulated_gain_reg  <= cfg_wdata[5:0];
                mmvc_pkg::CFG_MODULATED_WAVE:  modulated_wave_reg  <= cfg_wdata[1:0];
                mmvc_pkg::CFG_ATTACK_RATE:     attack_rate_reg     <= cfg_wdata[3:0];
                mmvc_pkg::CFG_RELEASE_RATE:    release_rate_reg    <= cfg_wdata[3:0];
            endcase
        end
    end

    // Parser next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (in_fire)
        begin
            unique case (phase_reg)
                mmvc_pkg::PHASE_STATUS:
                begin
                    if (in_byte < mmvc_pkg::SYSTEM_MIN)
                    begin
                        if (!in_byte[7])
                        begin
                            phase_next = mmvc_pkg::has_two_data(running_status_reg) ?
                                         mmvc_pkg::PHASE_DATA2 : mmvc_pkg::PHASE_STATUS;
                        end
                        else
                        begin
                            phase_next = mmvc_pkg::PHASE_DATA1;
                        end
                    end
                end
                mmvc_pkg::PHASE_DATA1:
                begin
                    phase_next = mmvc_pkg::has_two_data(current_status_reg) ?
                                 mmvc_pkg::PHASE_DATA2 : mmvc_pkg::PHASE_STATUS;
                end
                mmvc_pkg::PHASE_DATA2:
                begin
                    phase_next = mmvc_pkg::PHASE_STATUS;
                end
                default:
                begin
                    phase_next = mmvc_pkg::PHASE_STATUS;
                end
            endcase
        end
    end

    // Parser data registers and note commands.
    always_comb
    begin
        running_status_next = running_status_reg;
        current_status_next = current_status_reg;
        first_data_next     = first_data_reg;
        cmd_valid           = 1'b0;
        cmd.op              = (current_status_reg[7:4] == mmvc_pkg::KIND_NOTE_ON) ?
                              mmvc_pkg::OP_NOTE_ON : mmvc_pkg::OP_NOTE_OFF;
        cmd.pitch           = first_data_reg;
        if (in_fire)
        begin
            unique case (phase_reg)
                mmvc_pkg::PHASE_STATUS:
                begin
                    if (in_byte < mmvc_pkg::SYSTEM_MIN)
                    begin
                        if (!in_byte[7])
                        begin
                            first_data_next     = in_byte;
                            current_status_next = running_status_reg;
                        end
                        else
                        begin
                            running_status_next = in_byte;
                            current_status_next = in_byte;
                        end
                    end
                end
                mmvc_pkg::PHASE_DATA1:
                begin
                    first_data_next = in_byte;
                end
                mmvc_pkg::PHASE_DATA2:
                begin
                    cmd_valid = (current_status_reg[3:0] == mmvc_pkg::CHANNEL_0) &&
                                ((current_status_reg[7:4] == mmvc_pkg::KIND_NOTE_ON) ||
                                 (current_status_reg[7:4] == mmvc_pkg::KIND_NOTE_OFF));
                end
                default:
                begin
                    cmd_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= mmvc_pkg::PHASE_STATUS;
            running_status_reg <= 8'd0;
            current_status_reg <= 8'd0;
            first_data_reg     <= 8'd0;
        end
        else
        begin
            phase_reg          <= phase_next;
            running_status_reg <= running_status_next;
            current_status_reg <= current_status_next;
            first_data_reg     <= first_data_next;
        end
    end

    mmvc_engine #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready)
    );

    // Voice command formatting from the engine request and the configuration.
    assign octave_sum = {{2{carrier_octave_reg[3]}}, carrier_octave_reg} +
                        {2'b00, req.octave};

    always_comb
    begin
        if (req.gate_on)
        begin
            control_byte   = mmvc_pkg::CTRL_GATE | {5'd0, waveform_select_reg};
            out_tdata_next = {2'b00,
                              release_rate_reg, attack_rate_reg,
                              modulated_wave_reg, modulated_gain_reg,
                              message_wave_reg, message_gain_reg,
                              octave_sum,
                              req.octave, mmvc_pkg::note_delta(req.semitone),
                              control_byte};
        end
        else
        begin
            control_byte   = (waveform_select_reg == mmvc_pkg::WAVE_PM) ?
                             mmvc_pkg::CTRL_PM_OFF : 8'd0;
            out_tdata_next = {48'd0, control_byte};
        end
    end

    // Output register: takes a new command whenever it is empty or being drained.
    assign req_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            out_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            out_tdata_reg <= out_tdata_next;
            out_tuser_reg <= req.gate_on;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_tdata_reg;
    assign m_axis_tuser[0] = out_tuser_reg;

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;

    localparam int STACK_DEPTH = 16;
    localparam int SEMITONES = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    // Longest note-off walk plus output register, rounded up.
    localparam int SETTLE_CYCLES = 32;
    localparam int LONG_HOLD = 300;
    localparam logic [7:0] PITCH_MAX_POS = 8'h7F;
    localparam logic [3:0] KIND_PROGRAM = 4'hC;
    localparam logic [3:0] KIND_CHAN_PRESS = 4'hD;
    localparam logic [7:0] SYS_CLOCK = 8'hF8;
    localparam logic [7:0] SYS_SENSE = 8'hFE;
    localparam logic [11:0] SEMITONE_STEP [SEMITONES] = '{
        12'd702, 12'd744, 12'd788, 12'd835, 12'd885, 12'd937,
        12'd993, 12'd1052, 12'd1115, 12'd1181, 12'd1251, 12'd1326
    };

    typedef struct packed {
        logic        gate_on;
        logic [7:0]  control_byte;
        logic [15:0] phase_word;
        logic [5:0]  octave_sum;
        logic [7:0]  message_byte;
        logic [7:0]  modulated_byte;
        logic [7:0]  envelope_byte;
    } voice_cmd_t;

    typedef struct packed {
        logic [2:0] wave;
        logic [3:0] carrier;
        logic [5:0] msg_gain;
        logic [1:0] msg_wave;
        logic [5:0] mod_gain;
        logic [1:0] mod_wave;
        logic [3:0] attack;
        logic [3:0] release_rate;
    } patch_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [5:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] midi_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // [7:0] control_byte, [23:8] phase_word,
                                 // [29:24] octave_sum, [37:30] message_byte,
                                 // [45:38] modulated_byte, [53:46] envelope_byte
    logic [0:0]  m_axis_tuser;   // [0] gate_on

    midi_mono_voice_controller #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Voice settings as the block should hold them.
    logic [2:0] wave_code = 3'd4;
    logic [3:0] carrier_shift = 4'd0;
    logic [5:0] msg_gain = 6'd63;
    logic [1:0] msg_wave = 2'd0;
    logic [5:0] mod_gain = 6'd63;
    logic [1:0] mod_wave = 2'd0;
    logic [3:0] attack_rate = 4'd15;
    logic [3:0] release_rate = 4'd15;

    // Parser and pitch stack as the block should hold them.
    logic [7:0]            run_status = 8'h00;
    logic [7:0]            cur_status = 8'h00;
    logic [7:0]            first_data = 8'h00;
    mmvc_pkg::mmvc_phase_t midi_phase = mmvc_pkg::PHASE_STATUS;
    logic [7:0]            held [0:STACK_DEPTH-1] = '{default: 8'h00};
    int                    held_count = 0;
    logic [7:0]            last_pitch = 8'h00;

    voice_cmd_t voice_cmds_due [$];
    int         mismatches = 0;

    // Stimulus controls for the sender and the receiver.
    bit         tx_steady = 0;
    bit         rx_steady = 0;
    int         rx_hold_len = 0;
    logic [7:0] last_status_sent = 8'h00;

    function automatic bit two_data_bytes(input logic [7:0] status);
        case (status[7:4])
            mmvc_pkg::KIND_NOTE_OFF, mmvc_pkg::KIND_NOTE_ON, mmvc_pkg::KIND_POLY_PRESS,
            mmvc_pkg::KIND_CONTROL, mmvc_pkg::KIND_PITCH_BEND:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic voice_cmd_t gate_off_cmd();
        voice_cmd_t c;
        c = '0;
        c.control_byte = (wave_code == mmvc_pkg::WAVE_PM) ? mmvc_pkg::CTRL_PM_OFF : 8'h00;
        return c;
    endfunction

    // Voice command for a pitch: retriggered note in the playable range, else gate off.
    function automatic voice_cmd_t sound_pitch(input logic [7:0] pitch);
        voice_cmd_t c;
        logic [3:0] octave;
        int         semi;
        if (pitch < mmvc_pkg::PITCH_LOW || pitch > mmvc_pkg::PITCH_HIGH)
        begin
            c = gate_off_cmd();
        end
        else
        begin
            octave = 4'(pitch / SEMITONES + 1);
            semi = pitch % SEMITONES;
            c.gate_on = 1'b1;
            c.control_byte = mmvc_pkg::CTRL_GATE | {5'b0, wave_code};
            c.phase_word = {octave, SEMITONE_STEP[semi]};
            c.octave_sum = {{2{carrier_shift[3]}}, carrier_shift} + {2'b00, octave};
            c.message_byte = {msg_wave, msg_gain};
            c.modulated_byte = {mod_wave, mod_gain};
            c.envelope_byte = {release_rate, attack_rate};
        end
        return c;
    endfunction

    function automatic bit press_key(input logic [7:0] pitch, output voice_cmd_t cmd);
        bit hit;
        hit = 1'b0;
        cmd = '0;
        // A full stack ignores the note entirely.
        if (held_count < STACK_DEPTH - 1)
        begin
            held_count++;
            held[held_count] = pitch;
            if (pitch != last_pitch)
            begin
                cmd = sound_pitch(pitch);
                hit = 1'b1;
                last_pitch = pitch;
            end
        end
        return hit;
    endfunction

    function automatic bit lift_key(input logic [7:0] pitch, output voice_cmd_t cmd);
        int         idx;
        logic [7:0] top_pitch;
        bit         hit;
        idx = -1;
        hit = 1'b0;
        cmd = '0;
        // Search below the top; a match is squeezed out, otherwise the top is popped.
        for (int i = 1; i < held_count; i++)
            if (idx < 0 && held[i] == pitch)
                idx = i;
        if (idx >= 0)
            for (int j = idx; j < held_count; j++)
                held[j] = held[j + 1];
        if (held_count > 0)
            held_count--;
        top_pitch = held[held_count];
        if (top_pitch >= 8'd1 && top_pitch <= PITCH_MAX_POS)
        begin
            if (top_pitch != last_pitch)
            begin
                cmd = sound_pitch(top_pitch);
                hit = 1'b1;
            end
        end
        else
        begin
            cmd = gate_off_cmd();
            hit = 1'b1;
        end
        last_pitch = top_pitch;
        return hit;
    endfunction

    // Advances the parser by one byte; returns 1 when a voice command results.
    function automatic bit parse_midi_byte(input logic [7:0] b, output voice_cmd_t cmd);
        bit hit;
        hit = 1'b0;
        cmd = '0;
        case (midi_phase)
            mmvc_pkg::PHASE_STATUS:
            begin
                if (b < mmvc_pkg::SYSTEM_MIN)
                begin
                    if (!b[7])
                    begin
                        first_data = b;
                        cur_status = run_status;
                        midi_phase = two_data_bytes(cur_status) ?
                                     mmvc_pkg::PHASE_DATA2 : mmvc_pkg::PHASE_STATUS;
                    end
                    else
                    begin
                        run_status = b;
                        cur_status = b;
                        midi_phase = mmvc_pkg::PHASE_DATA1;
                    end
                end
            end
            mmvc_pkg::PHASE_DATA1:
            begin
                first_data = b;
                midi_phase = two_data_bytes(cur_status) ?
                             mmvc_pkg::PHASE_DATA2 : mmvc_pkg::PHASE_STATUS;
            end
            default:
            begin
                midi_phase = mmvc_pkg::PHASE_STATUS;
                if (cur_status[3:0] == mmvc_pkg::CHANNEL_0)
                begin
                    if (cur_status[7:4] == mmvc_pkg::KIND_NOTE_ON)
                        hit = press_key(first_data, cmd);
                    else if (cur_status[7:4] == mmvc_pkg::KIND_NOTE_OFF)
                        hit = lift_key(first_data, cmd);
                end
            end
        endcase
        return hit;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Register writes and accepted bytes update the prediction.
    always @(posedge clk)
    begin
        voice_cmd_t cmd;
        if (rst_n && cfg_wr_en)
        begin
            case (cfg_index)
                mmvc_pkg::CFG_WAVEFORM_SELECT: wave_code = cfg_wdata[2:0];
                mmvc_pkg::CFG_CARRIER_OCTAVE:  carrier_shift = cfg_wdata[3:0];
                mmvc_pkg::CFG_MESSAGE_GAIN:    msg_gain = cfg_wdata[5:0];
                mmvc_pkg::CFG_MESSAGE_WAVE:    msg_wave = cfg_wdata[1:0];
                mmvc_pkg::CFG_MODULATED_GAIN:  mod_gain = cfg_wdata[5:0];
                mmvc_pkg::CFG_MODULATED_WAVE:  mod_wave = cfg_wdata[1:0];
                mmvc_pkg::CFG_ATTACK_RATE:     attack_rate = cfg_wdata[3:0];
                mmvc_pkg::CFG_RELEASE_RATE:    release_rate = cfg_wdata[3:0];
                default:                       ;
            endcase
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
            if (parse_midi_byte(s_axis_tdata, cmd))
                voice_cmds_due.push_back(cmd);
    end

    task automatic check_field(input string name, input logic [15:0] expv,
                               input logic [15:0] got);
        if (expv !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, expv, got);
            mismatches++;
        end
    endtask

    // Each voice command transaction is checked against the oldest expectation.
    always @(posedge clk)
    begin
        voice_cmd_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (voice_cmds_due.size() == 0)
            begin
                $error("unexpected voice command: tuser %0h, tdata %0h",
                       m_axis_tuser, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = voice_cmds_due.pop_front();
                check_field("gate_on", 16'(want.gate_on), 16'(m_axis_tuser[0]));
                check_field("control_byte", 16'(want.control_byte),
                            16'(m_axis_tdata[7:0]));
                check_field("phase_word", want.phase_word, m_axis_tdata[23:8]);
                check_field("octave_sum", 16'(want.octave_sum),
                            16'(m_axis_tdata[29:24]));
                check_field("message_byte", 16'(want.message_byte),
                            16'(m_axis_tdata[37:30]));
                check_field("modulated_byte", 16'(want.modulated_byte),
                            16'(m_axis_tdata[45:38]));
                check_field("envelope_byte", 16'(want.envelope_byte),
                            16'(m_axis_tdata[53:46]));
            end
        end
    end

    // Receiver: random stalls per transaction unless steady, or a long hold on request.
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (rx_hold_len > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_len) @(posedge clk);
                rx_hold_len = 0;
            end
            stall = rx_steady ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready) && rx_hold_len == 0);
        end
    end

    // Ends the run when nothing moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("midi_mono_voice_controller: mismatch");
        $finish;
    end

    // Offers one byte after a random gap, none when steady, and returns once it is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 8);
        repeat (gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Stops sending until every expected voice command is out and the block has settled.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        // Lets the last accepted byte reach the expectation queue.
        @(posedge clk);
        while (voice_cmds_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Upper bits beyond the register width are junk that the block must drop.
    task automatic write_reg(input logic [2:0] idx, input logic [5:0] val, input int width);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= 6'(($urandom << width) | val);
        @(posedge clk);
    endtask

    task automatic load_patch(input patch_t p);
        wait_drained();
        write_reg(mmvc_pkg::CFG_WAVEFORM_SELECT, 6'(p.wave), 3);
        write_reg(mmvc_pkg::CFG_CARRIER_OCTAVE, 6'(p.carrier), 4);
        write_reg(mmvc_pkg::CFG_MESSAGE_GAIN, p.msg_gain, 6);
        write_reg(mmvc_pkg::CFG_MESSAGE_WAVE, 6'(p.msg_wave), 2);
        write_reg(mmvc_pkg::CFG_MODULATED_GAIN, p.mod_gain, 6);
        write_reg(mmvc_pkg::CFG_MODULATED_WAVE, 6'(p.mod_wave), 2);
        write_reg(mmvc_pkg::CFG_ATTACK_RATE, 6'(p.attack), 4);
        write_reg(mmvc_pkg::CFG_RELEASE_RATE, 6'(p.release_rate), 4);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic patch_t random_patch();
        patch_t p;
        p.wave = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(1, 4));
        p.carrier = 4'($urandom_range(0, 15));
        p.msg_gain = 6'($urandom_range(0, 63));
        p.msg_wave = 2'($urandom_range(0, 3));
        p.mod_gain = 6'($urandom_range(0, 63));
        p.mod_wave = 2'($urandom_range(0, 3));
        p.attack = 4'($urandom_range(0, 15));
        p.release_rate = 4'($urandom_range(0, 15));
        return p;
    endfunction

    // Completes a half-sent message so the next byte lands in status position.
    // Only called while idle, when the predicted parser state is settled.
    task automatic close_open_message();
        int n;
        case (midi_phase)
            mmvc_pkg::PHASE_DATA1: n = two_data_bytes(cur_status) ? 2 : 1;
            mmvc_pkg::PHASE_DATA2: n = 1;
            default:               n = 0;
        endcase
        repeat (n) send_byte(8'h01);
        last_status_sent = 8'h00;
    endtask

    function automatic logic [7:0] pick_pitch();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 8'(36 + $urandom_range(0, SEMITONES - 1));
        else if (roll < 80)
            return 8'($urandom_range(0, 127));
        else if (roll < 92)
            case ($urandom_range(0, 5))
                0:       return 8'd0;
                1:       return mmvc_pkg::PITCH_LOW - 8'd1;
                2:       return mmvc_pkg::PITCH_LOW;
                3:       return mmvc_pkg::PITCH_HIGH;
                4:       return mmvc_pkg::PITCH_HIGH + 8'd1;
                default: return PITCH_MAX_POS;
            endcase
        else
            return 8'($urandom_range(128, 255));
    endfunction

    function automatic logic [7:0] pick_velocity();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 8'd0;
        else if (roll == 1)
            return 8'($urandom_range(128, 255));
        else
            return 8'($urandom_range(0, 127));
    endfunction

    // Mostly well-formed note traffic on channel 0, with other messages,
    // system bytes, stray bytes and cut-off notes mixed in.
    task automatic random_traffic(input int n_bytes);
        int         sent;
        int         roll;
        logic [7:0] status;
        sent = 0;
        last_status_sent = 8'h00;
        while (sent < n_bytes)
        begin
            roll = $urandom_range(0, 99);
            if (roll >= 90)
            begin
                if (roll < 95)
                begin
                    send_byte(8'($urandom_range(mmvc_pkg::SYSTEM_MIN, 255)));
                    sent += 1;
                end
                else if (roll < 98)
                begin
                    send_byte(8'($urandom_range(0, 255)));
                    sent += 1;
                end
                else
                begin
                    send_byte({mmvc_pkg::KIND_NOTE_ON, mmvc_pkg::CHANNEL_0});
                    send_byte(pick_pitch());
                    sent += 2;
                end
                last_status_sent = 8'h00;
            end
            else
            begin
                if (roll < 40)
                    status = {mmvc_pkg::KIND_NOTE_ON, mmvc_pkg::CHANNEL_0};
                else if (roll < 75)
                    status = {mmvc_pkg::KIND_NOTE_OFF, mmvc_pkg::CHANNEL_0};
                else
                    status = {4'($urandom_range(mmvc_pkg::KIND_NOTE_OFF,
                                                mmvc_pkg::KIND_PITCH_BEND)),
                              4'($urandom_range(0, 15))};
                if (status != last_status_sent || $urandom_range(0, 3) == 0)
                begin
                    send_byte(status);
                    sent += 1;
                    last_status_sent = status;
                end
                send_byte(pick_pitch());
                sent += 1;
                if (two_data_bytes(status))
                begin
                    send_byte(pick_velocity());
                    sent += 1;
                end
            end
        end
    endtask

    // Parser corner cases and note extremes under the reset settings.
    task automatic test_parser_cases();
        // Data before any status byte runs under status 0 and is ignored.
        send_byte(8'h45);
        // System byte in status position is dropped.
        send_byte(SYS_CLOCK);
        // Lowest and highest playable pitches; zero velocity still plays.
        send_byte({mmvc_pkg::KIND_NOTE_ON, mmvc_pkg::CHANNEL_0});
        send_byte(mmvc_pkg::PITCH_LOW);
        send_byte(8'h7F);
        send_byte(mmvc_pkg::PITCH_HIGH);
        send_byte(8'h00);
        // Running status survives a system byte; a repeated pitch is silent.
        send_byte(SYS_SENSE);
        send_byte(mmvc_pkg::PITCH_HIGH);
        send_byte(8'h40);
        // Pitch below the playable range gives gate off.
        send_byte(mmvc_pkg::PITCH_LOW - 8'd1);
        send_byte(8'h01);
        // Bytes with the top bit set in data position are data.
        send_byte({mmvc_pkg::KIND_NOTE_ON, mmvc_pkg::CHANNEL_0});
        send_byte(8'hF5);
        send_byte(8'h80);
        // Note-off removes a buried pitch, leaving a negative pitch on top.
        send_byte({mmvc_pkg::KIND_NOTE_OFF, mmvc_pkg::CHANNEL_0});
        send_byte(mmvc_pkg::PITCH_HIGH);
        send_byte(8'h00);
        // Note-off of a pitch not held pops the top.
        send_byte(8'h30);
        send_byte(8'h00);
        // One-data message and a note on another channel are ignored.
        send_byte({KIND_PROGRAM, 4'h3});
        send_byte(8'h10);
        send_byte({mmvc_pkg::KIND_NOTE_ON, 4'h1});
        send_byte(8'h3C);
        send_byte(8'h40);
    endtask

    // Fills the pitch stack past its limit, then releases past empty.
    task automatic test_stack_fill(input patch_t p);
        load_patch(p);
        close_open_message();
        send_byte({mmvc_pkg::KIND_NOTE_ON, mmvc_pkg::CHANNEL_0});
        repeat (STACK_DEPTH + 1)
        begin
            send_byte(8'(mmvc_pkg::PITCH_LOW +
                         $urandom_range(0, mmvc_pkg::PITCH_HIGH - mmvc_pkg::PITCH_LOW)));
            send_byte(8'($urandom_range(1, 127)));
        end
        send_byte({mmvc_pkg::KIND_NOTE_OFF, mmvc_pkg::CHANNEL_0});
        repeat (STACK_DEPTH + 2)
        begin
            send_byte(pick_pitch());
            send_byte(8'h00);
        end
    endtask

    // Back-to-back transactions on both sides.
    task automatic test_streaming(input patch_t p, input int n_bytes);
        load_patch(p);
        tx_steady = 1;
        rx_steady = 1;
        random_traffic(n_bytes);
        tx_steady = 0;
        rx_steady = 0;
    endtask

    // The receiver holds off while note traffic keeps coming, so the input stalls.
    task automatic test_backpressure(input patch_t p);
        logic [7:0] pitch;
        load_patch(p);
        close_open_message();
        rx_hold_len = LONG_HOLD;
        repeat (6)
        begin
            pitch = 8'($urandom_range(mmvc_pkg::PITCH_LOW, mmvc_pkg::PITCH_HIGH));
            send_byte({mmvc_pkg::KIND_NOTE_ON, mmvc_pkg::CHANNEL_0});
            send_byte(pitch);
            send_byte(pick_velocity());
            send_byte({mmvc_pkg::KIND_NOTE_OFF, mmvc_pkg::CHANNEL_0});
            send_byte(pitch);
            send_byte(8'h00);
        end
    endtask

    task automatic test_random_settings(input int phases, input int n_bytes);
        repeat (phases)
        begin
            load_patch(random_patch());
            random_traffic(n_bytes);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= mmvc_pkg::CFG_WAVEFORM_SELECT;
        cfg_wdata <= 6'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_parser_cases();
        test_stack_fill('{3'd1, 4'h8, 6'd0, 2'd0, 6'd0, 2'd0, 4'd0, 4'd0});
        test_streaming('{mmvc_pkg::WAVE_PM, 4'h7, 6'd63, 2'd3, 6'd63, 2'd3, 4'd15, 4'd15},
                       60);
        test_backpressure(random_patch());
        test_random_settings(4, 50);
        test_stack_fill(random_patch());

        wait_drained();
        if (mismatches == 0 && voice_cmds_due.size() == 0)
            $display("midi_mono_voice_controller: match");
        else
            $display("midi_mono_voice_controller: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
